// ----- design/dolist_pkg.sv -----
// Shared constants for the ordered key list engine: sizes, command and status codes.
package dolist_pkg;

    // List depth and derived widths
    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OFF_W    = 6;
    localparam int CMP_W    = (CNT_W > OFF_W) ? CNT_W : OFF_W;
    localparam int KEY_W    = 64;
    localparam int CMD_W    = 3;
    localparam int ST_W     = 3;
    localparam int OUT_W    = 6;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INS_AT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BOT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RM_AT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RM_KEY  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MTF     = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
    localparam logic [ST_W-1:0] ST_OFFSET   = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_NOCHANGE = 3'd4;

endpackage

// ----- design/dedup_ordered_list_engine.sv -----
// Ordered list of unique 64-bit keys with insert, remove, find and move-to-top.
//
// Usage:
//   Requests arrive on in_valid/in_ready with cmd, item_key and offset. Each
//   request yields one result on out_valid/out_ready carrying status, position
//   (index of item_key after the command, or the count if absent) and count.
//   The keys live in one synchronous RAM (one write port, one read port,
//   registered read). Every request first scans the list for item_key, one
//   entry per cycle, then commands that change the list shift entries one per
//   cycle through the RAM read/write ports.
//   One request is in work at a time; in_ready is high when the engine is idle.
//   Results sit in an output register; the next request is taken while that
//   result waits, and the engine holds its finished result until out_ready.
//   Reset empties the list (count zero) at once; no clearing pass is needed,
//   since entries at or beyond the count are never read.
module dedup_ordered_list_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dolist_pkg::CMD_W-1:0]      cmd,
    input  logic [dolist_pkg::KEY_W-1:0]      item_key,
    input  logic [dolist_pkg::OFF_W-1:0]      offset,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dolist_pkg::ST_W-1:0]       status,
    output logic [dolist_pkg::OUT_W-1:0]      position,
    output logic [dolist_pkg::OUT_W-1:0]      count
);

    localparam int IDX_W = dolist_pkg::IDX_W;
    localparam int CNT_W = dolist_pkg::CNT_W;
    localparam int CMP_W = dolist_pkg::CMP_W;
    localparam int KEY_W = dolist_pkg::KEY_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_SHDN = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;
    localparam logic [2:0] S_SHUP = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // Key storage
    logic [KEY_W-1:0] mem [dolist_pkg::CAPACITY];
    logic [KEY_W-1:0] rdata_reg;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;

    // Control and request registers
    logic [2:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [CNT_W-1:0]             ptr_reg, ptr_next;
    logic                         pend_reg, pend_next;
    logic [IDX_W-1:0]             pend_addr_reg, pend_addr_next;
    logic                         found_reg, found_next;
    logic [CNT_W-1:0]             at_reg, at_next;
    logic [CNT_W-1:0]             p_reg, p_next;
    logic [CNT_W-1:0]             lim_reg, lim_next;
    logic [dolist_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [KEY_W-1:0]             key_reg, key_next;
    logic [dolist_pkg::OFF_W-1:0] off_reg, off_next;
    logic [dolist_pkg::ST_W-1:0]  st_reg, st_next;
    logic [CNT_W-1:0]             pos_reg, pos_next;
    logic                         ov_reg, ov_next;
    logic [dolist_pkg::ST_W-1:0]  ost_reg, ost_next;
    logic [dolist_pkg::OUT_W-1:0] opos_reg, opos_next;
    logic [dolist_pkg::OUT_W-1:0] ocnt_reg, ocnt_next;

    logic [CMP_W-1:0] off_w;
    logic [CMP_W-1:0] cnt_w;
    logic [CNT_W-1:0] p_sel;
    logic [CNT_W-1:0] cnt_dec;
    logic             hit;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign status    = ost_reg;
    assign position  = opos_reg;
    assign count     = ocnt_reg;

    // RAM write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        found_next     = found_reg;
        at_next        = at_reg;
        p_next         = p_reg;
        lim_next       = lim_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        off_next       = off_reg;
        st_next        = st_reg;
        pos_next       = pos_reg;
        ov_next        = ov_reg;
        ost_next       = ost_reg;
        opos_next      = opos_reg;
        ocnt_next      = ocnt_reg;
        we             = 1'b0;
        waddr          = pend_addr_reg;
        wdata          = rdata_reg;
        re             = 1'b0;
        raddr          = ptr_reg[IDX_W-1:0];

        off_w   = CMP_W'(off_reg);
        cnt_w   = CMP_W'(cnt_reg);
        cnt_dec = cnt_reg - CNT_W'(1);
        p_sel   = (cmd_reg == dolist_pkg::CMD_INS_AT) ? CNT_W'(off_reg) : cnt_reg;
        hit     = pend_reg && (rdata_reg == key_reg);

        // Drop the result once the receiver takes it
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    key_next   = item_key;
                    off_next   = offset;
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_SRCH;
                end
            end

            // Scan entries for the key, one read per cycle
            S_SRCH:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    at_next    = CNT_W'(pend_addr_reg);
                    pend_next  = 1'b0;
                    state_next = S_DEC;
                end
                else if (ptr_reg != cnt_reg)
                begin
                    re             = 1'b1;
                    raddr          = ptr_reg[IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        found_next = 1'b0;
                        at_next    = cnt_reg;
                        state_next = S_DEC;
                    end
                end
            end

            // Decide the outcome and set up any shift
            S_DEC:
            begin
                pend_next  = 1'b0;
                st_next    = dolist_pkg::ST_NOCHANGE;
                pos_next   = at_reg;
                state_next = S_FIN;
                case (cmd_reg)
                    dolist_pkg::CMD_INS_AT, dolist_pkg::CMD_INS_BOT:
                    begin
                        if ((cmd_reg == dolist_pkg::CMD_INS_AT) && (off_w > cnt_w))
                        begin
                            st_next = dolist_pkg::ST_OFFSET;
                        end
                        else if (found_reg)
                        begin
                            st_next = dolist_pkg::ST_DUP;
                        end
                        else if (cnt_reg == CNT_W'(dolist_pkg::CAPACITY))
                        begin
                            st_next = dolist_pkg::ST_FULL;
                        end
                        else
                        begin
                            st_next    = dolist_pkg::ST_DONE;
                            pos_next   = p_sel;
                            p_next     = p_sel;
                            ptr_next   = cnt_reg;
                            cnt_next   = cnt_reg + CNT_W'(1);
                            state_next = S_SHDN;
                        end
                    end
                    dolist_pkg::CMD_RM_AT:
                    begin
                        if (off_w < cnt_w)
                        begin
                            st_next    = dolist_pkg::ST_DONE;
                            ptr_next   = CNT_W'(off_reg);
                            lim_next   = cnt_dec;
                            cnt_next   = cnt_dec;
                            state_next = S_SHUP;
                            if (!found_reg || (at_reg == CNT_W'(off_reg)))
                            begin
                                pos_next = cnt_dec;
                            end
                            else if (at_reg > CNT_W'(off_reg))
                            begin
                                pos_next = at_reg - CNT_W'(1);
                            end
                            else
                            begin
                                pos_next = at_reg;
                            end
                        end
                    end
                    dolist_pkg::CMD_RM_KEY:
                    begin
                        if (found_reg)
                        begin
                            st_next    = dolist_pkg::ST_DONE;
                            pos_next   = cnt_dec;
                            ptr_next   = at_reg;
                            lim_next   = cnt_dec;
                            cnt_next   = cnt_dec;
                            state_next = S_SHUP;
                        end
                    end
                    dolist_pkg::CMD_FIND:
                    begin
                        st_next = dolist_pkg::ST_DONE;
                    end
                    dolist_pkg::CMD_MTF:
                    begin
                        if (found_reg)
                        begin
                            st_next    = dolist_pkg::ST_DONE;
                            pos_next   = '0;
                            p_next     = '0;
                            ptr_next   = at_reg;
                            state_next = S_SHDN;
                        end
                    end
                    default:
                    begin
                        st_next = dolist_pkg::ST_NOCHANGE;
                    end
                endcase
            end

            // Move entries toward the bottom, bottom-most first
            S_SHDN:
            begin
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = pend_addr_reg;
                    wdata = rdata_reg;
                end
                if (ptr_reg != p_reg)
                begin
                    re             = 1'b1;
                    raddr          = IDX_W'(ptr_reg - CNT_W'(1));
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_reg - CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_PUT;
                    end
                end
            end

            // Write the new key into the opened slot
            S_PUT:
            begin
                we         = 1'b1;
                waddr      = p_reg[IDX_W-1:0];
                wdata      = key_reg;
                state_next = S_FIN;
            end

            // Move entries toward the top to close the gap
            S_SHUP:
            begin
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = pend_addr_reg;
                    wdata = rdata_reg;
                end
                if (ptr_reg != lim_reg)
                begin
                    re             = 1'b1;
                    raddr          = IDX_W'(ptr_reg + CNT_W'(1));
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            // Hand the result to the output register when it is free
            S_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ost_next   = st_reg;
                    opos_next  = dolist_pkg::OUT_W'(pos_reg);
                    ocnt_next  = dolist_pkg::OUT_W'(cnt_reg);
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
        found_reg     <= found_next;
        at_reg        <= at_next;
        p_reg         <= p_next;
        lim_reg       <= lim_next;
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        off_reg       <= off_next;
        st_reg        <= st_next;
        pos_reg       <= pos_next;
        ost_reg       <= ost_next;
        opos_reg      <= opos_next;
        ocnt_reg      <= ocnt_next;
    end

endmodule
